[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the two-stack core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, quiet while reset is asserted
`define DSSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds while reset is asserted
`define DSSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSSM_ASSERT(lbl, prop, msg)
`define DSSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/dssm_pkg.sv]
// Types, codes and defaults for the two-stack shared memory core.
package dssm_pkg;

    localparam int DSSM_DEPTH = 16;

    // Operation codes
    localparam logic [3:0] FN_PUSH1  = 4'd0;
    localparam logic [3:0] FN_POP1   = 4'd1;
    localparam logic [3:0] FN_DUP1   = 4'd2;
    localparam logic [3:0] FN_LIST1  = 4'd3;
    localparam logic [3:0] FN_RLIST1 = 4'd4;
    localparam logic [3:0] FN_PUSH2  = 4'd5;
    localparam logic [3:0] FN_POP2   = 4'd6;
    localparam logic [3:0] FN_DUP2   = 4'd7;
    localparam logic [3:0] FN_LIST2  = 4'd8;
    localparam logic [3:0] FN_RLIST2 = 4'd9;
    localparam logic [3:0] FN_CHECK  = 4'd10;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SAME  = 2'd3;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               equal;
        logic               last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FIN,
        S_LIST,
        S_CA,
        S_CB,
        S_RES
    } state_t;

endpackage

[rtl/core/dual_stack_shared_memory_core.sv]
// Two stacks in one shared word store, with listing and equality check.
//
// Usage:
//   Commands arrive on cmd/cmd_valid/cmd_stall; an item is taken when cmd_valid
//   is high and cmd_stall is low. Results leave on res/res_valid/res_stall and
//   are taken when res_valid is high and res_stall is low. Every command gives
//   one or more result items; the final one carries last.
//   One command is worked at a time; cmd_stall is high until the sequencer
//   has handed its final result to the output register.
//   Push, failure cases, unchanged listings, checks decided by size and
//   unused codes pass from S_START to S_RES, which loads the output register;
//   pop and duplicate pass through S_FIN between the two for the read.
//   A listing of n elements gives one element per cycle while the output
//   register is free to take it, limited by the single memory read port.
//   The check reads two entries per compared pair.
//   Reset empties both stacks and clears the listed marks; store contents are
//   not cleared. A stalled result holds in the output register, and the
//   sequencer waits on it before producing the next result.
`include "assert_macros.svh"

module dual_stack_shared_memory_core
    import dssm_pkg::*;
#(
    parameter int DEPTH = DSSM_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] ADDR_MAX = AW'(DEPTH - 1);
    localparam logic [CW:0]   OCC_MAX  = (CW + 1)'(DEPTH);

    state_t             state_reg, state_next;
    logic [3:0]         func_reg, func_next;
    logic signed [31:0] value_reg, value_next;
    logic [CW-1:0]      cl_reg, cl_next;
    logic [CW-1:0]      ch_reg, ch_next;
    logic               lf_reg, lf_next;
    logic               lr_reg, lr_next;
    logic               hf_reg, hf_next;
    logic               hr_reg, hr_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               up_reg, up_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic signed [31:0] a_reg, a_next;
    res_t               hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_data;

    logic [CW:0]        occ;
    logic               full;
    logic               out_free;
    logic               emit;
    res_t               emit_item;

    dssm_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Occupancy of the shared store
    assign occ      = {1'b0, cl_reg} + {1'b0, ch_reg};
    assign full     = occ >= OCC_MAX;
    assign out_free = !out_valid_reg || !res_stall;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cl_reg        <= '0;
            ch_reg        <= '0;
            lf_reg        <= 1'b0;
            lr_reg        <= 1'b0;
            hf_reg        <= 1'b0;
            hr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cl_reg        <= cl_next;
            ch_reg        <= ch_next;
            lf_reg        <= lf_next;
            lr_reg        <= lr_next;
            hf_reg        <= hf_next;
            hr_reg        <= hr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        up_reg    <= up_next;
        rem_reg   <= rem_next;
        a_reg     <= a_next;
        hold_reg  <= hold_next;
        out_reg   <= out_next;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        value_next = value_reg;
        cl_next    = cl_reg;
        ch_next    = ch_reg;
        lf_next    = lf_reg;
        lr_next    = lr_reg;
        hf_next    = hf_reg;
        hr_next    = hr_reg;
        idx_next   = idx_reg;
        up_next    = up_reg;
        rem_next   = rem_reg;
        a_next     = a_reg;
        hold_next  = hold_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = value_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        emit       = 1'b0;
        emit_item  = hold_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    func_next  = cmd.func;
                    value_next = cmd.value;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                hold_next.data   = '0;
                hold_next.status = ST_OK;
                hold_next.equal  = 1'b0;
                hold_next.last   = 1'b1;
                state_next       = S_RES;
                unique case (func_reg) inside
                    FN_PUSH1:
                    begin
                        lf_next = 1'b0;
                        lr_next = 1'b0;
                        if (full)
                        begin
                            hold_next.status = ST_OVF;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(cl_reg);
                            cl_next = cl_reg + 1'b1;
                        end
                    end
                    FN_PUSH2:
                    begin
                        hf_next = 1'b0;
                        hr_next = 1'b0;
                        if (full)
                        begin
                            hold_next.status = ST_OVF;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = ADDR_MAX - AW'(ch_reg);
                            ch_next = ch_reg + 1'b1;
                        end
                    end
                    FN_POP1, FN_DUP1:
                    begin
                        lf_next = 1'b0;
                        lr_next = 1'b0;
                        if (cl_reg == '0)
                        begin
                            hold_next.status = ST_EMPTY;
                        end
                        else if (func_reg == FN_DUP1 && full)
                        begin
                            hold_next.status = ST_OVF;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(cl_reg - 1'b1);
                            state_next = S_FIN;
                        end
                    end
                    FN_POP2, FN_DUP2:
                    begin
                        hf_next = 1'b0;
                        hr_next = 1'b0;
                        if (ch_reg == '0)
                        begin
                            hold_next.status = ST_EMPTY;
                        end
                        else if (func_reg == FN_DUP2 && full)
                        begin
                            hold_next.status = ST_OVF;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(DEPTH_C - ch_reg);
                            state_next = S_FIN;
                        end
                    end
                    FN_LIST1, FN_RLIST1:
                    begin
                        if (cl_reg == '0)
                        begin
                            hold_next.status = ST_EMPTY;
                        end
                        else if ((func_reg == FN_LIST1) ? lf_reg : lr_reg)
                        begin
                            hold_next.status = ST_SAME;
                        end
                        else
                        begin
                            if (func_reg == FN_LIST1)
                            begin
                                lf_next  = 1'b1;
                                idx_next = AW'(cl_reg - 1'b1);
                                up_next  = 1'b0;
                            end
                            else
                            begin
                                lr_next  = 1'b1;
                                idx_next = '0;
                                up_next  = 1'b1;
                            end
                            rem_next   = cl_reg;
                            rd_en      = 1'b1;
                            rd_addr    = idx_next;
                            state_next = S_LIST;
                        end
                    end
                    FN_LIST2, FN_RLIST2:
                    begin
                        if (ch_reg == '0)
                        begin
                            hold_next.status = ST_EMPTY;
                        end
                        else if ((func_reg == FN_LIST2) ? hf_reg : hr_reg)
                        begin
                            hold_next.status = ST_SAME;
                        end
                        else
                        begin
                            if (func_reg == FN_LIST2)
                            begin
                                hf_next  = 1'b1;
                                idx_next = AW'(DEPTH_C - ch_reg);
                                up_next  = 1'b1;
                            end
                            else
                            begin
                                hr_next  = 1'b1;
                                idx_next = ADDR_MAX;
                                up_next  = 1'b0;
                            end
                            rem_next   = ch_reg;
                            rd_en      = 1'b1;
                            rd_addr    = idx_next;
                            state_next = S_LIST;
                        end
                    end
                    FN_CHECK:
                    begin
                        if (cl_reg != ch_reg)
                        begin
                            hold_next.equal = 1'b0;
                        end
                        else if (cl_reg == '0)
                        begin
                            hold_next.equal = 1'b1;
                        end
                        else
                        begin
                            idx_next   = '0;
                            rem_next   = cl_reg;
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_CA;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Read data for pop and duplicate is now available
            S_FIN:
            begin
                state_next = S_RES;
                unique case (func_reg)
                    FN_POP1:
                    begin
                        cl_next        = cl_reg - 1'b1;
                        hold_next.data = rd_data;
                    end
                    FN_POP2:
                    begin
                        ch_next        = ch_reg - 1'b1;
                        hold_next.data = rd_data;
                    end
                    FN_DUP1:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(cl_reg);
                        wr_data = rd_data;
                        cl_next = cl_reg + 1'b1;
                    end
                    FN_DUP2:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_MAX - AW'(ch_reg);
                        wr_data = rd_data;
                        ch_next = ch_reg + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // One element per cycle while the output register takes it
            S_LIST:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    emit_item.data   = rd_data;
                    emit_item.status = ST_OK;
                    emit_item.equal  = 1'b0;
                    emit_item.last   = (rem_reg == CW'(1));
                    if (rem_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = up_reg ? idx_reg + 1'b1 : idx_reg - 1'b1;
                        rem_next = rem_reg - 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_next;
                    end
                end
            end

            // Check: capture the low-side element, fetch its mirror
            S_CA:
            begin
                a_next     = rd_data;
                rd_en      = 1'b1;
                rd_addr    = ADDR_MAX - idx_reg;
                state_next = S_CB;
            end

            // Check: compare the pair and move on
            S_CB:
            begin
                if (a_reg != rd_data)
                begin
                    hold_next.equal = 1'b0;
                    state_next      = S_RES;
                end
                else if (rem_reg == CW'(1))
                begin
                    hold_next.equal = 1'b1;
                    state_next      = S_RES;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rem_next   = rem_reg - 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = idx_next;
                    state_next = S_CA;
                end
            end

            S_RES:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_item;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // The two stacks never claim more than the store holds
    `DSSM_ASSERT_ALWAYS(a_occ_bound, occ <= OCC_MAX, "stacks exceed store depth")
    // A listed mark on stack one implies stack one is not empty
    `DSSM_ASSERT(a_listed_nonempty, (lf_reg || lr_reg) |-> (cl_reg != '0), "listed empty stack")
    // Every store write grows the combined occupancy by one
    `DSSM_ASSERT(a_write_grows, wr_en |=> (occ == $past(occ) + 1'b1), "write without push")
    // Only listing elements come out without the last mark, always with ok status
    `DSSM_ASSERT(a_nonlast_ok, (res_valid && !res.last) |-> (res.status == ST_OK), "bad mid item")

endmodule

[rtl/core/dssm_ram.sv]
// Single-port-write, single-port-read word store with registered read data.
module dssm_ram
    import dssm_pkg::*;
#(
    parameter int DEPTH = DSSM_DEPTH,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic signed [31:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic signed [31:0] rd_data
);

    logic signed [31:0] mem_reg [DEPTH];
    logic signed [31:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
